// ===== src/tbb_pkg.sv =====
// ----------------------------------------------------------------------------
// tbb_pkg
// Shared types and constants for the text bounding box block: register
// indexes, control character codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package tbb_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_WRAP_ENABLE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_WIDTH = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LINE_ADVANCE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FIRST_CHAR   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LAST_CHAR    = 3'd4;

  // control character codes
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_CR      = 8'd13;

  // extreme values after a restart
  localparam logic [15:0] LEAST_INIT    = 16'h7FFF;
  localparam logic [15:0] GREATEST_INIT = 16'hFFFF;

  // register reset values
  localparam logic [14:0] SCREEN_WIDTH_RST = 15'd320;
  localparam logic [7:0]  LINE_ADVANCE_RST = 8'd8;
  localparam logic [7:0]  FIRST_CHAR_RST   = 8'd32;
  localparam logic [7:0]  LAST_CHAR_RST    = 8'd126;

  typedef struct packed {
    logic        wrap_enable;
    logic [14:0] screen_width;
    logic [7:0]  line_advance;
    logic [7:0]  first_char;
    logic [7:0]  last_char;
  } cfg_t;

  typedef struct packed {
    logic        is_first;
    logic        is_last;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [7:0]  char_code;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [7:0]  glyph_x_offset;
    logic [7:0]  glyph_y_offset;
    logic [7:0]  glyph_x_advance;
  } item_t;

  // all positions are 16-bit two's complement
  typedef struct packed {
    logic [15:0] cursor_x;
    logic [15:0] cursor_y;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] least_x;
    logic [15:0] least_y;
    logic [15:0] greatest_x;
    logic [15:0] greatest_y;
  } state_t;

  typedef struct packed {
    logic [15:0] box_height;
    logic [15:0] box_width;
    logic [15:0] box_y;
    logic [15:0] box_x;
  } box_t;

endpackage

// ===== src/tbb_step.sv =====
// ----------------------------------------------------------------------------
// tbb_step
// Combinational update for one character: restart, newline, wrap, glyph
// extents and cursor advance, plus the bounding box of the updated state.
// ----------------------------------------------------------------------------
module tbb_step (
  input  tbb_pkg::cfg_t   cfg,
  input  tbb_pkg::item_t  item,
  input  tbb_pkg::state_t state_cur,
  output tbb_pkg::state_t state_nxt,
  output tbb_pkg::box_t   box
);
  import tbb_pkg::*;

  state_t             base;
  logic               is_nl;
  logic               is_glyph;
  logic signed [17:0] wrap_sum;
  logic               do_wrap;
  logic [15:0]        cy_adv;
  logic [15:0]        cx_line;
  logic [15:0]        cy_line;
  logic [15:0]        x1;
  logic [15:0]        y1;
  logic [15:0]        x2;
  logic [15:0]        y2;

  always_comb begin
    base = state_cur;
    if (item.is_first) begin
      base.cursor_x   = item.start_x;
      base.cursor_y   = item.start_y;
      base.origin_x   = item.start_x;
      base.origin_y   = item.start_y;
      base.least_x    = LEAST_INIT;
      base.least_y    = LEAST_INIT;
      base.greatest_x = GREATEST_INIT;
      base.greatest_y = GREATEST_INIT;
    end
  end

  assign is_nl    = (item.char_code == CHAR_NEWLINE);
  assign is_glyph = !is_nl && (item.char_code != CHAR_CR)
                    && (item.char_code >= cfg.first_char)
                    && (item.char_code <= cfg.last_char);

  // right edge test at full precision, no 16-bit wrap
  assign wrap_sum = $signed({{2{base.cursor_x[15]}}, base.cursor_x})
                  + $signed({{10{item.glyph_x_offset[7]}}, item.glyph_x_offset})
                  + $signed({10'd0, item.glyph_width});
  assign do_wrap  = cfg.wrap_enable && (wrap_sum > $signed({3'd0, cfg.screen_width}));

  assign cy_adv  = base.cursor_y + {8'd0, cfg.line_advance};
  assign cx_line = do_wrap ? 16'd0 : base.cursor_x;
  assign cy_line = do_wrap ? cy_adv : base.cursor_y;

  assign x1 = cx_line + {{8{item.glyph_x_offset[7]}}, item.glyph_x_offset};
  assign y1 = cy_line + {{8{item.glyph_y_offset[7]}}, item.glyph_y_offset};
  // zero-size glyph gives an edge one left of / above its origin
  assign x2 = x1 + {8'd0, item.glyph_width} - 16'd1;
  assign y2 = y1 + {8'd0, item.glyph_height} - 16'd1;

  always_comb begin
    state_nxt = base;
    if (is_nl) begin
      state_nxt.cursor_x = 16'd0;
      state_nxt.cursor_y = cy_adv;
    end else if (is_glyph) begin
      state_nxt.cursor_x = cx_line + {8'd0, item.glyph_x_advance};
      state_nxt.cursor_y = cy_line;
      if ($signed(x1) < $signed(base.least_x))    state_nxt.least_x    = x1;
      if ($signed(y1) < $signed(base.least_y))    state_nxt.least_y    = y1;
      if ($signed(x2) > $signed(base.greatest_x)) state_nxt.greatest_x = x2;
      if ($signed(y2) > $signed(base.greatest_y)) state_nxt.greatest_y = y2;
    end
  end

  // each axis falls back to the origin on its own when empty
  always_comb begin
    box.box_x      = state_nxt.origin_x;
    box.box_width  = 16'd0;
    box.box_y      = state_nxt.origin_y;
    box.box_height = 16'd0;
    if ($signed(state_nxt.greatest_x) >= $signed(state_nxt.least_x)) begin
      box.box_x     = state_nxt.least_x;
      box.box_width = state_nxt.greatest_x - state_nxt.least_x + 16'd1;
    end
    if ($signed(state_nxt.greatest_y) >= $signed(state_nxt.least_y)) begin
      box.box_y      = state_nxt.least_y;
      box.box_height = state_nxt.greatest_y - state_nxt.least_y + 16'd1;
    end
  end

endmodule

// ===== src/text_bounding_box_top.sv =====
// ----------------------------------------------------------------------------
// text_bounding_box_top
// Measures the pixel bounding box of a string in a proportional bitmap font,
// one character per transaction, and returns the box on the last character.
//
//  channel | direction | payload
//  in_     | slave     | tdata: character and glyph metrics, tlast: last char,
//          |           | tuser: restart flag
//  out_    | master    | tdata: box x, y, width, height
//  cfg_    | write     | index 0..4 selects the register, wdata its value
//
//  One character is taken every cycle unless a last character waits on a
//  stalled output; a result is registered in out_box_r via s1_item_r.
//  The cursor and extreme registers close a loop through tbb_step alone.
//  Reset is synchronous; it presets state and config and clears both valids.
//  A stalled result only holds back a following last character: other
//  characters keep flowing behind it.
// ----------------------------------------------------------------------------
module text_bounding_box_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // start_x, start_y, char_code, glyph_width, glyph_height,
  // glyph_x_offset, glyph_y_offset, glyph_x_advance
  input  logic [tbb_pkg::InDataW-1:0]   in_tdata,
  input  logic                          in_tlast,
  // is_first
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // box_x, box_y, box_width, box_height
  output logic [tbb_pkg::OutDataW-1:0]  out_tdata,
  input  logic                          cfg_we,
  input  logic [tbb_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tbb_pkg::CfgDataW-1:0]  cfg_wdata
);
  import tbb_pkg::*;

  cfg_t   cfg_r;
  item_t  in_item;
  item_t  s1_item_r;
  logic   s1_valid_r;
  logic   s1_fire;
  logic   out_free;
  state_t state_r;
  state_t state_nxt;
  box_t   box_nxt;
  box_t   out_box_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wrap_enable  <= 1'b1;
      cfg_r.screen_width <= SCREEN_WIDTH_RST;
      cfg_r.line_advance <= LINE_ADVANCE_RST;
      cfg_r.first_char   <= FIRST_CHAR_RST;
      cfg_r.last_char    <= LAST_CHAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WRAP_ENABLE:  cfg_r.wrap_enable  <= cfg_wdata[0];
        REG_SCREEN_WIDTH: cfg_r.screen_width <= cfg_wdata[14:0];
        REG_LINE_ADVANCE: cfg_r.line_advance <= cfg_wdata[7:0];
        REG_FIRST_CHAR:   cfg_r.first_char   <= cfg_wdata[7:0];
        REG_LAST_CHAR:    cfg_r.last_char    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.is_first        = in_tuser;
    in_item.is_last         = in_tlast;
    in_item.start_x         = in_tdata[15:0];
    in_item.start_y         = in_tdata[31:16];
    in_item.char_code       = in_tdata[39:32];
    in_item.glyph_width     = in_tdata[47:40];
    in_item.glyph_height    = in_tdata[55:48];
    in_item.glyph_x_offset  = in_tdata[63:56];
    in_item.glyph_y_offset  = in_tdata[71:64];
    in_item.glyph_x_advance = in_tdata[79:72];
  end

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_item_r.is_last || out_free);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= in_item;
    end
  end

  tbb_step u_step (
    .cfg       (cfg_r),
    .item      (s1_item_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .box       (box_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.cursor_x   <= 16'd0;
      state_r.cursor_y   <= 16'd0;
      state_r.origin_x   <= 16'd0;
      state_r.origin_y   <= 16'd0;
      state_r.least_x    <= LEAST_INIT;
      state_r.least_y    <= LEAST_INIT;
      state_r.greatest_x <= GREATEST_INIT;
      state_r.greatest_y <= GREATEST_INIT;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && s1_item_r.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_fire && s1_item_r.is_last) begin
      out_box_r <= box_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_box_r;

endmodule

// ===== src/tbb_checker.sv =====
// ----------------------------------------------------------------------------
// tbb_checker
// Port-level checks on the text bounding box block, bound to the top level.
// ----------------------------------------------------------------------------
module tbb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          in_tlast,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [tbb_pkg::OutDataW-1:0]  out_tdata
);

  // no result survives a reset
  a_out_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // the input side is open straight after reset
  a_in_open: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // a fresh result follows an accepted last character
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a last character");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind text_bounding_box_top tbb_checker u_tbb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/text_bounding_box_top_tb.sv =====
// ----------------------------------------------------------------------------
// text_bounding_box_top_tb
// Self-checking testbench for the text bounding box block. Characters with
// glyph metrics go in on the input stream with random gaps. A built-in
// predictor tracks the cursor, origin and extremes and works out each box.
// Boxes that come out of the block, under random back-pressure, are compared
// field by field with the predicted ones. Directed strings cover the field
// extremes and control codes; random strings then run over several layouts.
// ----------------------------------------------------------------------------
module text_bounding_box_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tbb_pkg::*;

  localparam int SettleCycles = 4;
  localparam int StallLimit   = 4000;
  localparam int ReportLimit  = 10;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                in_tlast;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  text_bounding_box_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // font layout as last written, and the measurement state
  cfg_t               layout;
  logic signed [15:0] cur_x, cur_y, org_x, org_y;
  logic signed [15:0] lo_x, lo_y, hi_x, hi_y;

  box_t boxes_due[$];
  box_t got_box, want_box;
  int   chars_sent;
  int   boxes_checked;
  int   box_errors;
  int   layouts_used;
  int   idle_cycles;
  bit   steady;

  // ---------------------------------------------------------------------------
  // predictor: one accepted character, box pushed when it is the last one

  function automatic void measure_char(item_t ch);
    int                 cx, xo, yo, gw, gh;
    logic signed [15:0] x1, y1, x2, y2, bx, by;
    logic [15:0]        bw, bh;
    xo = $signed(ch.glyph_x_offset);
    yo = $signed(ch.glyph_y_offset);
    gw = ch.glyph_width;
    gh = ch.glyph_height;
    if (ch.is_first) begin
      cur_x = ch.start_x;
      cur_y = ch.start_y;
      org_x = ch.start_x;
      org_y = ch.start_y;
      lo_x  = LEAST_INIT;
      lo_y  = LEAST_INIT;
      hi_x  = GREATEST_INIT;
      hi_y  = GREATEST_INIT;
    end
    if (ch.char_code == CHAR_NEWLINE) begin
      cur_x = '0;
      cur_y = cur_y + layout.line_advance;
    end else if (ch.char_code != CHAR_CR && ch.char_code >= layout.first_char &&
                 ch.char_code <= layout.last_char) begin
      cx = cur_x;
      // wrap test is done at full precision
      if (layout.wrap_enable && (cx + xo + gw > int'(layout.screen_width))) begin
        cur_x = '0;
        cur_y = cur_y + layout.line_advance;
      end
      x1 = 16'(cur_x + xo);
      y1 = 16'(cur_y + yo);
      x2 = 16'(x1 + gw - 1);
      y2 = 16'(y1 + gh - 1);
      if (x1 < lo_x) lo_x = x1;
      if (y1 < lo_y) lo_y = y1;
      if (x2 > hi_x) hi_x = x2;
      if (y2 > hi_y) hi_y = y2;
      cur_x = cur_x + ch.glyph_x_advance;
    end
    if (ch.is_last) begin
      bx = org_x;
      by = org_y;
      bw = '0;
      bh = '0;
      if (hi_x >= lo_x) begin
        bx = lo_x;
        bw = 16'(hi_x - lo_x + 1);
      end
      if (hi_y >= lo_y) begin
        by = lo_y;
        bh = 16'(hi_y - lo_y + 1);
      end
      boxes_due.push_back('{box_height: bh, box_width: bw, box_y: by, box_x: bx});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // shared helpers

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic item_t glyph_char(bit first, bit last, int sx, int sy, int code,
                                       int w, int h, int xo, int yo, int xa);
    item_t ch;
    ch.is_first        = first;
    ch.is_last         = last;
    ch.start_x         = 16'(sx);
    ch.start_y         = 16'(sy);
    ch.char_code       = 8'(code);
    ch.glyph_width     = 8'(w);
    ch.glyph_height    = 8'(h);
    ch.glyph_x_offset  = 8'(xo);
    ch.glyph_y_offset  = 8'(yo);
    ch.glyph_x_advance = 8'(xa);
    return ch;
  endfunction

  // valid stays high after a transaction so that a following char with no gap
  // goes straight on; settle lowers it
  task automatic send_char(item_t ch);
    int gap;
    gap = gap_length();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ch.glyph_x_advance, ch.glyph_y_offset, ch.glyph_x_offset,
                  ch.glyph_height, ch.glyph_width, ch.char_code, ch.start_y, ch.start_x};
    in_tlast  <= ch.is_last;
    in_tuser  <= ch.is_first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    measure_char(ch);
    chars_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (boxes_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apply_layout(cfg_t c);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_WRAP_ENABLE;
    cfg_wdata <= CfgDataW'(c.wrap_enable);
    @(posedge clk);
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_wdata <= CfgDataW'(c.screen_width);
    @(posedge clk);
    cfg_index <= REG_LINE_ADVANCE;
    cfg_wdata <= CfgDataW'(c.line_advance);
    @(posedge clk);
    cfg_index <= REG_FIRST_CHAR;
    cfg_wdata <= CfgDataW'(c.first_char);
    @(posedge clk);
    cfg_index <= REG_LAST_CHAR;
    cfg_wdata <= CfgDataW'(c.last_char);
    @(posedge clk);
    cfg_we <= 1'b0;
    layout = c;
    layouts_used++;
  endtask

  function automatic item_t random_char();
    item_t ch;
    int    pick, w;
    ch   = '0;
    pick = $urandom_range(0, 99);
    if (pick < 8) ch.char_code = CHAR_NEWLINE;
    else if (pick < 12) ch.char_code = CHAR_CR;
    else if (pick < 20 || layout.first_char > layout.last_char) ch.char_code = 8'($urandom);
    else ch.char_code = 8'($urandom_range(layout.first_char, layout.last_char));
    if ($urandom_range(0, 4) == 0) begin
      {ch.glyph_width, ch.glyph_height, ch.glyph_x_offset} = 24'($urandom);
      {ch.glyph_y_offset, ch.glyph_x_advance} = 16'($urandom);
    end else begin
      w = $urandom_range(0, 12);
      ch.glyph_width     = 8'(w);
      ch.glyph_height    = 8'($urandom_range(0, 16));
      ch.glyph_x_offset  = 8'($urandom_range(0, 4) - 2);
      ch.glyph_y_offset  = 8'(0 - $urandom_range(0, 16));
      ch.glyph_x_advance = 8'(w + $urandom_range(0, 2));
    end
    if ($urandom_range(0, 3) == 0) begin
      {ch.start_x, ch.start_y} = $urandom;
    end else begin
      ch.start_x = 16'($urandom_range(0, layout.screen_width + 40) - 40);
      ch.start_y = 16'($urandom_range(0, 300) - 40);
    end
    return ch;
  endfunction

  // mostly well-formed strings, with the odd missing restart or early box
  task automatic send_random_string();
    int    len;
    item_t ch;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      ch = random_char();
      ch.is_first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
      ch.is_last  = (i == len - 1) ? ($urandom_range(0, 19) != 0)
                                   : ($urandom_range(0, 29) == 0);
      send_char(ch);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests

  // measurement from the reset state, and state kept after a box
  task automatic test_reset_state();
    send_char(glyph_char(0, 1, 0, 0, 65, 5, 7, 0, -7, 6));
    send_char(glyph_char(0, 1, 0, 0, CHAR_CR, 3, 3, 1, 1, 3));
  endtask

  task automatic test_edge_glyphs();
    // extreme start and metrics, sums wrapping at 16 bits
    send_char(glyph_char(1, 0, -32768, 32767, 126, 255, 255, -128, 127, 255));
    send_char(glyph_char(0, 0, 0, 0, 32, 0, 0, 127, -128, 0));
    send_char(glyph_char(0, 0, 0, 0, CHAR_NEWLINE, 9, 9, 0, 0, 9));
    send_char(glyph_char(0, 0, 0, 0, 31, 9, 9, 0, 0, 9));
    send_char(glyph_char(0, 0, 0, 0, 127, 9, 9, 0, 0, 9));
    send_char(glyph_char(0, 0, 0, 0, 255, 9, 9, 0, 0, 9));
    send_char(glyph_char(0, 0, 0, 0, 0, 9, 9, 0, 0, 9));
    send_char(glyph_char(0, 1, 0, 0, 90, 255, 1, 127, 0, 4));
    // zero-width glyph leaves the x axis empty
    send_char(glyph_char(1, 1, 32767, -32768, 66, 0, 9, 0, 0, 3));
    // no glyph at all: origin and zero size
    send_char(glyph_char(1, 1, 1234, -77, CHAR_NEWLINE, 0, 0, 0, 0, 0));
    // second glyph crosses the screen edge and wraps
    send_char(glyph_char(1, 0, 300, 0, 72, 10, 8, 0, -8, 11));
    send_char(glyph_char(0, 1, 0, 0, 73, 10, 8, 0, -8, 11));
  endtask

  // newline and carriage return stay control codes inside a full font range
  task automatic test_control_codes();
    apply_layout('{wrap_enable: 1'b0, screen_width: 15'd1, line_advance: 8'd255,
                   first_char: 8'd0, last_char: 8'd255});
    send_char(glyph_char(1, 0, -5, -5, 0, 255, 255, -128, -128, 255));
    send_char(glyph_char(0, 0, 0, 0, CHAR_NEWLINE, 7, 7, 3, 3, 7));
    send_char(glyph_char(0, 0, 0, 0, CHAR_CR, 7, 7, 3, 3, 7));
    send_char(glyph_char(0, 1, 0, 0, 255, 255, 1, 127, 127, 255));
  endtask

  task automatic test_empty_font();
    apply_layout('{wrap_enable: 1'b1, screen_width: 15'h7FFF, line_advance: 8'd0,
                   first_char: 8'd200, last_char: 8'd100});
    send_char(glyph_char(1, 0, 10, 10, 65, 4, 4, 0, 0, 4));
    send_char(glyph_char(0, 0, 0, 0, CHAR_NEWLINE, 4, 4, 0, 0, 4));
    send_char(glyph_char(0, 0, 0, 0, 150, 4, 4, 0, 0, 4));
    send_char(glyph_char(0, 1, 0, 0, CHAR_CR, 4, 4, 0, 0, 4));
    apply_layout('{wrap_enable: 1'b1, screen_width: 15'h7FFF, line_advance: 8'd0,
                   first_char: 8'd255, last_char: 8'd255});
    send_char(glyph_char(1, 1, 0, 0, 255, 1, 1, 0, 0, 1));
  endtask

  // a box on every char with no gaps on either side, then a full pause
  task automatic test_back_to_back();
    item_t ch;
    apply_layout('{wrap_enable: 1'b1, screen_width: SCREEN_WIDTH_RST,
                   line_advance: LINE_ADVANCE_RST, first_char: FIRST_CHAR_RST,
                   last_char: LAST_CHAR_RST});
    steady = 1'b1;
    for (int i = 0; i < 30; i++) begin
      ch = random_char();
      ch.is_first = 1'($urandom_range(0, 1));
      ch.is_last  = 1'b1;
      send_char(ch);
    end
    steady = 1'b0;
    settle();
  endtask

  task automatic test_random_layouts();
    cfg_t c;
    int   stop_at;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: c = '{1'b1, 15'h7FFF, 8'd0, 8'd32, 8'd126};
        1: c = '{1'b1, 15'd1, 8'd255, 8'd0, 8'd255};
        2: c = '{1'b0, 15'd320, 8'd8, 8'd33, 8'd126};
        default: begin
          c.wrap_enable  = ($urandom_range(0, 3) != 0);
          c.screen_width = ($urandom_range(0, 5) == 0) ? 15'($urandom_range(1, 32767))
                                                       : 15'($urandom_range(16, 640));
          c.line_advance = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(6, 20));
          if ($urandom_range(0, 2) == 0) begin
            c.first_char = 8'($urandom);
            c.last_char  = 8'($urandom);
          end else begin
            c.first_char = FIRST_CHAR_RST;
            c.last_char  = LAST_CHAR_RST;
          end
        end
      endcase
      apply_layout(c);
      // stretches without gaps now and then
      steady  = (phase == 5);
      stop_at = chars_sent + 88;
      while (chars_sent < stop_at) send_random_string();
      steady = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_box = box_t'(out_tdata);
      if (boxes_due.size() == 0) begin
        box_errors++;
        if (box_errors <= ReportLimit)
          $display("unexpected box x=%0d y=%0d w=%0d h=%0d", $signed(got_box.box_x),
                   $signed(got_box.box_y), got_box.box_width, got_box.box_height);
      end else begin
        want_box = boxes_due.pop_front();
        boxes_checked++;
        if (got_box.box_x !== want_box.box_x || got_box.box_y !== want_box.box_y ||
            got_box.box_width !== want_box.box_width ||
            got_box.box_height !== want_box.box_height) begin
          box_errors++;
          if (box_errors <= ReportLimit)
            $display("box %0d mismatch: expected x=%0d y=%0d w=%0d h=%0d, got x=%0d y=%0d w=%0d h=%0d",
                     boxes_checked, $signed(want_box.box_x), $signed(want_box.box_y),
                     want_box.box_width, want_box.box_height, $signed(got_box.box_x),
                     $signed(got_box.box_y), got_box.box_width, got_box.box_height);
        end
      end
    end
  end

  // output back-pressure
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      int stall;
      stall = gap_length();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // watchdog on cycles without any transaction or register write
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("no transaction for %0d cycles", StallLimit);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    in_tuser    <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_WRAP_ENABLE;
    cfg_wdata   <= '0;
    idle_cycles <= 0;
    steady        = 1'b0;
    chars_sent    = 0;
    boxes_checked = 0;
    box_errors    = 0;
    layouts_used  = 0;
    layout = '{wrap_enable: 1'b1, screen_width: SCREEN_WIDTH_RST,
               line_advance: LINE_ADVANCE_RST, first_char: FIRST_CHAR_RST,
               last_char: LAST_CHAR_RST};
    cur_x = '0;
    cur_y = '0;
    org_x = '0;
    org_y = '0;
    lo_x  = LEAST_INIT;
    lo_y  = LEAST_INIT;
    hi_x  = GREATEST_INIT;
    hi_y  = GREATEST_INIT;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_edge_glyphs();
    test_control_codes();
    test_empty_font();
    test_back_to_back();
    test_random_layouts();
    settle();

    $display("sent %0d characters over %0d font layouts after the reset one", chars_sent,
             layouts_used);
    $display("checked %0d boxes, wrap on and off, control codes and empty axes",
             boxes_checked);
    if (box_errors == 0 && boxes_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d box errors", box_errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
